[hdl/bxl_pkg.sv]
// Shared types, codes and helpers for the byte transliterator.
// No dependencies; every other file but bxl_checker refers to it by scoped names.
package bxl_pkg;

    localparam int SET_CAPACITY_DEF = 256;
    localparam int LEN_W            = 9;   // set lengths 0..256
    localparam int ADDR_W           = 4;   // three 32-bit registers at 0, 4, 8

    typedef enum logic [1:0] {
        CMD_XLATE = 2'd0,
        CMD_SRC   = 2'd1,
        CMD_TGT   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_COMPLEMENT = 2'd0,
        REG_DELETE     = 2'd1,
        REG_SQUEEZE    = 2'd2
    } reg_idx_t;

    // source lookup result, stage 1
    typedef struct packed {
        logic       matched;
        logic [7:0] pos;
    } src_info_t;

    // mapped byte, stage 2
    typedef struct packed {
        logic [7:0] c;
        logic       tm;    // c is in the target set
    } tgt_info_t;

    function automatic logic [2:0] pop4(input logic [3:0] v);
        pop4 = {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
    endfunction

    function automatic logic [4:0] pop16(input logic [15:0] v);
        pop16 = {2'b00, pop4(v[3:0])}  + {2'b00, pop4(v[7:4])}
              + {2'b00, pop4(v[11:8])} + {2'b00, pop4(v[15:12])};
    endfunction

endpackage

[hdl/byte_transliterator.sv]
// Top level of the byte transliterator: register port, pipeline control.
// Depends on bxl_pkg, bxl_src, bxl_tgt and bxl_squeeze.
//
// Usage
//   Input channel (item_valid / item_stall) carries cmd and value: translate
//   a byte, append to the source set, append to the target set, or clear
//   both sets. Only translate transactions can produce a result, on the
//   output channel (result_valid / result_stall) as out_byte; deleted and
//   squeezed bytes produce none.
//   Registers complement_mode, delete_mode and squeeze_mode sit at APB byte
//   addresses 0, 4 and 8 (bit 0); write them only while the block is idle.
// Timing
//   One transaction per cycle unless a stalled result freezes the pipeline.
//   For a translated byte the position memory and lookup flops load at the
//   accepting edge, the target memory read follows, then the squeeze compare
//   loads the result register. Appends update the membership flops at
//   acceptance, so a translate right behind an append already sees it.
// Reset and stall
//   Reset empties both sets, clears the registers and forgets the previous
//   output byte; no clearing pass is needed. While a result is held by
//   result_stall the whole pipeline freezes and item_stall is raised.
module byte_transliterator #(
    parameter int SET_CAPACITY = bxl_pkg::SET_CAPACITY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bxl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,

    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [1:0]                 cmd,
    input  logic [7:0]                 value,

    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [7:0]                 out_byte
);

    logic               complement_reg;
    logic               delete_reg;
    logic               squeeze_reg;
    logic               cfg_write;
    bxl_pkg::reg_idx_t  reg_idx;

    bxl_pkg::cmd_t      cmd_code;
    logic               en;
    logic               accept;
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    bxl_pkg::src_info_t src_info;
    bxl_pkg::tgt_info_t tgt_info;

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = bxl_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            complement_reg <= 1'b0;
            delete_reg     <= 1'b0;
            squeeze_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                bxl_pkg::REG_COMPLEMENT: complement_reg <= pwdata[0];
                bxl_pkg::REG_DELETE:     delete_reg     <= pwdata[0];
                bxl_pkg::REG_SQUEEZE:    squeeze_reg    <= pwdata[0];
                default:                 ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            bxl_pkg::REG_COMPLEMENT: prdata = {31'd0, complement_reg};
            bxl_pkg::REG_DELETE:     prdata = {31'd0, delete_reg};
            bxl_pkg::REG_SQUEEZE:    prdata = {31'd0, squeeze_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline control: all stages advance together unless the result
    // register is full and stalled.
    // ---------------------------------------------------------------
    assign cmd_code   = bxl_pkg::cmd_t'(cmd);
    assign en         = !result_valid || !result_stall;
    assign item_stall = !en;
    assign accept     = item_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept && (cmd_code == bxl_pkg::CMD_XLATE);
            // delete mode drops matched bytes without touching the squeeze state
            s2_valid_reg <= s1_valid_reg && !(src_info.matched && delete_reg);
        end
    end

    bxl_src #(
        .SET_CAPACITY   (SET_CAPACITY)
    ) u_src (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .accept          (accept),
        .cmd             (cmd_code),
        .value           (value),
        .complement_mode (complement_reg),
        .src_info        (src_info)
    );

    bxl_tgt #(
        .SET_CAPACITY   (SET_CAPACITY)
    ) u_tgt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .accept   (accept),
        .cmd      (cmd_code),
        .value    (value),
        .src_info (src_info),
        .tgt_info (tgt_info)
    );

    bxl_squeeze u_squeeze (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .s2_valid     (s2_valid_reg),
        .tgt_info     (tgt_info),
        .squeeze_mode (squeeze_reg),
        .out_valid    (result_valid),
        .out_byte     (out_byte)
    );

endmodule

[hdl/bxl_src.sv]
// Source set: membership flops, per-row prefix counts, first-position memory.
// Depends on bxl_pkg. Match flag and position come from flops loaded at accept.
module bxl_src #(
    parameter int SET_CAPACITY = bxl_pkg::SET_CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                accept,
    input  bxl_pkg::cmd_t       cmd,
    input  logic [7:0]          value,
    input  logic                complement_mode,
    output bxl_pkg::src_info_t  src_info
);

    logic [255:0]                 member_reg;
    logic [7:0]                   prefix_reg [16];   // members below row j
    logic [bxl_pkg::LEN_W-1:0]    slen_reg;
    logic [7:0]                   pos_mem [256];
    logic [7:0]                   pos_rdata_reg;

    logic [7:0]                   value_s1_reg;
    logic [7:0]                   prefix_s1_reg;
    logic [4:0]                   inrow_s1_reg;
    logic                         m0_s1_reg;
    logic                         matched_s1_reg;

    logic [3:0]                   hi;
    logic [3:0]                   lo;
    logic [15:0]                  row_mask;
    logic                         matched_now;
    logic                         append_src;
    logic                         new_member;
    logic                         clear_sets;
    logic [7:0]                   below;
    logic [7:0]                   rank;

    assign hi       = value[7:4];
    assign lo       = value[3:0];
    assign row_mask = member_reg[{hi, 4'b0000} +: 16] & ((16'h0001 << lo) - 16'h0001);

    assign matched_now = complement_mode ? ((value != 8'd0) && !member_reg[value])
                                         : member_reg[value];

    assign append_src = accept && (cmd == bxl_pkg::CMD_SRC) &&
                        (slen_reg < bxl_pkg::LEN_W'(SET_CAPACITY));
    assign new_member = append_src && !member_reg[value];
    assign clear_sets = accept && (cmd == bxl_pkg::CMD_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_reg <= '0;
            slen_reg   <= '0;
            for (int j = 0; j < 16; j++)
            begin
                prefix_reg[j] <= 8'd0;
            end
        end
        else if (clear_sets)
        begin
            member_reg <= '0;
            slen_reg   <= '0;
            for (int j = 0; j < 16; j++)
            begin
                prefix_reg[j] <= 8'd0;
            end
        end
        else if (append_src)
        begin
            slen_reg <= slen_reg + 1'b1;
            if (new_member)
            begin
                member_reg[value] <= 1'b1;
                for (int j = 1; j < 16; j++)
                begin
                    if (j > int'(hi))
                    begin
                        prefix_reg[j] <= prefix_reg[j] + 8'd1;
                    end
                end
            end
        end
    end

    // repeated bytes keep their first position
    always_ff @(posedge clk)
    begin
        if (new_member)
        begin
            pos_mem[value] <= slen_reg[7:0];
        end
        if (en)
        begin
            pos_rdata_reg <= pos_mem[value];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_s1_reg   <= value;
            prefix_s1_reg  <= prefix_reg[hi];
            inrow_s1_reg   <= bxl_pkg::pop16(row_mask);
            m0_s1_reg      <= member_reg[0];
            matched_s1_reg <= matched_now;
        end
    end

    // complement rank: non-members in 1..b-1
    assign below = prefix_s1_reg + {3'b000, inrow_s1_reg};
    assign rank  = value_s1_reg - below - {7'd0, !m0_s1_reg};

    assign src_info.matched = matched_s1_reg;
    assign src_info.pos     = complement_mode ? rank : pos_rdata_reg;

endmodule

[hdl/bxl_tgt.sv]
// Target set: membership flops, length and element memory; clamps position.
// Depends on bxl_pkg and the stage-1 lookup from bxl_src.
module bxl_tgt #(
    parameter int SET_CAPACITY = bxl_pkg::SET_CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                accept,
    input  bxl_pkg::cmd_t       cmd,
    input  logic [7:0]          value,
    input  bxl_pkg::src_info_t  src_info,
    output bxl_pkg::tgt_info_t  tgt_info
);

    localparam int TIDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

    logic [255:0]                 member_reg;
    logic [bxl_pkg::LEN_W-1:0]    tlen_reg;
    logic [7:0]                   tgt_mem [SET_CAPACITY];
    logic [7:0]                   tb_rdata_reg;

    logic [7:0]                   value_s1_reg;
    logic [bxl_pkg::LEN_W-1:0]    tlen_s1_reg;
    logic                         tm_s1_reg;
    logic [7:0]                   value_s2_reg;
    logic                         use_tgt_s2_reg;
    logic                         tm_s2_reg;

    logic                         append_tgt;
    logic                         clear_sets;
    logic [bxl_pkg::LEN_W-1:0]    pos_ext;
    logic [bxl_pkg::LEN_W-1:0]    idx;

    assign append_tgt = accept && (cmd == bxl_pkg::CMD_TGT) &&
                        (tlen_reg < bxl_pkg::LEN_W'(SET_CAPACITY));
    assign clear_sets = accept && (cmd == bxl_pkg::CMD_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_reg <= '0;
            tlen_reg   <= '0;
        end
        else if (clear_sets)
        begin
            member_reg <= '0;
            tlen_reg   <= '0;
        end
        else if (append_tgt)
        begin
            member_reg[value] <= 1'b1;
            tlen_reg          <= tlen_reg + 1'b1;
        end
    end

    // past the end of the set the last element is used
    assign pos_ext = {{(bxl_pkg::LEN_W-8){1'b0}}, src_info.pos};
    assign idx     = (pos_ext >= tlen_s1_reg) ? (tlen_s1_reg - 1'b1) : pos_ext;

    // a pending read always sits below the length snapshot, so never on the
    // entry being appended in the same cycle
    always_ff @(posedge clk)
    begin
        if (append_tgt)
        begin
            tgt_mem[tlen_reg[TIDX_W-1:0]] <= value;
        end
        if (en)
        begin
            tb_rdata_reg <= tgt_mem[idx[TIDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_s1_reg   <= value;
            tlen_s1_reg    <= tlen_reg;
            tm_s1_reg      <= member_reg[value];
            value_s2_reg   <= value_s1_reg;
            use_tgt_s2_reg <= src_info.matched && (tlen_s1_reg != '0);
            tm_s2_reg      <= tm_s1_reg;
        end
    end

    // a byte taken from the target set is a member of it by construction
    assign tgt_info.c  = use_tgt_s2_reg ? tb_rdata_reg : value_s2_reg;
    assign tgt_info.tm = use_tgt_s2_reg || tm_s2_reg;

endmodule

[hdl/bxl_squeeze.sv]
// Output stage: squeeze of repeated target bytes and the result register.
// Depends on bxl_pkg and the stage-2 mapping from bxl_tgt.
module bxl_squeeze (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                s2_valid,
    input  bxl_pkg::tgt_info_t  tgt_info,
    input  logic                squeeze_mode,
    output logic                out_valid,
    output logic [7:0]          out_byte
);

    logic       prev_valid_reg;
    logic [7:0] prev_byte_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       squeezed;

    assign squeezed = squeeze_mode && prev_valid_reg &&
                      (prev_byte_reg == tgt_info.c) && tgt_info.tm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s2_valid && !squeezed;
            if (s2_valid)
            begin
                prev_valid_reg <= 1'b1;
            end
        end
    end

    // squeezed bytes still update the previous byte
    always_ff @(posedge clk)
    begin
        if (en && s2_valid)
        begin
            prev_byte_reg <= tgt_info.c;
            out_byte_reg  <= tgt_info.c;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule

[hdl/bxl_checker.sv]
// Port-level checks for byte_transliterator, attached with a bind.
// Depends only on the top level's ports.
module bxl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] out_byte
);

    // input is held back only by a stalled result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall == (result_valid && result_stall))
        else $error("item_stall does not follow the stalled result");

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(out_byte))
        else $error("stalled result changed");

    // free cycles without input drain the pipeline
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!item_valid && !item_stall) ##1 (!item_valid && !item_stall)
        ##1 (!item_valid && !item_stall) |=> !result_valid)
        else $error("result without a translate transaction");

endmodule

bind byte_transliterator bxl_checker u_bxl_checker (.*);

[tb/byte_transliterator_test.sv]
// Self-checking testbench for byte_transliterator: directed mapping and mode checks,
// full-set overflow and random set/translate sessions under varying backpressure.
// Depends on bxl_pkg and the byte_transliterator RTL.
module byte_transliterator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY       = bxl_pkg::SET_CAPACITY_DEF;
    localparam int PIPE_SETTLE    = 6;     // pipeline is three deep; margin on top
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side

    // ------------------------------------------------------------------
    // Clock, reset and DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                       clk;
    logic                       rst_n        = 1'b0;
    logic                       psel         = 1'b0;
    logic                       penable      = 1'b0;
    logic                       pwrite       = 1'b0;
    logic [bxl_pkg::ADDR_W-1:0] paddr        = '0;
    logic [31:0]                pwdata       = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       item_valid   = 1'b0;
    logic                       item_stall;
    bxl_pkg::cmd_t              item_cmd     = bxl_pkg::CMD_XLATE;
    logic [7:0]                 item_value   = 8'h00;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic [7:0]                 out_byte;

    byte_transliterator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (item_cmd),
        .value        (item_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow state of the transliterator
    // ------------------------------------------------------------------
    bit         mode_complement;
    bit         mode_delete;
    bit         mode_squeeze;
    bit         src_member [256];
    bit [7:0]   src_pos    [256];
    bit [7:0]   tgt_byte   [256];
    bit         tgt_member [256];
    int         src_len;
    int         tgt_len;
    bit         last_out_valid;   // previous output byte, kept or squeezed
    bit [7:0]   last_out;

    logic [7:0] expected_bytes [$];   // translated bytes still to come out
    logic [7:0] wanted_byte;
    int         items_sent;
    int         mismatch_count;
    int         idle_cycles;
    int         send_idle_pct = 28;
    int         recv_idle_pct = 45;

    // Applies one transaction to the shadow state; returns 1 with the byte
    // that must come out, or 0 when the transaction produces nothing.
    function automatic bit predict_transliteration(bxl_pkg::cmd_t op, bit [7:0] v,
                                                   output bit [7:0] mapped);
        bit      matched;
        int      rank;
        bit [7:0] c;
        matched = 1'b0;
        rank    = 0;
        c       = v;
        mapped  = 8'h00;
        case (op)
            bxl_pkg::CMD_SRC:
            begin
                if (src_len < CAPACITY)
                begin
                    // a repeated byte counts toward the length, keeps its first slot
                    if (!src_member[v])
                    begin
                        src_member[v] = 1'b1;
                        src_pos[v]    = src_len[7:0];
                    end
                    src_len++;
                end
                return 1'b0;
            end
            bxl_pkg::CMD_TGT:
            begin
                if (tgt_len < CAPACITY)
                begin
                    tgt_byte[tgt_len[7:0]] = v;
                    tgt_member[v]          = 1'b1;
                    tgt_len++;
                end
                return 1'b0;
            end
            bxl_pkg::CMD_CLEAR:
            begin
                // sets only: modes and the previous output byte survive
                for (int k = 0; k < 256; k++)
                begin
                    src_member[k] = 1'b0;
                    tgt_member[k] = 1'b0;
                end
                src_len = 0;
                tgt_len = 0;
                return 1'b0;
            end
            default:
            begin
                if (mode_complement)
                begin
                    // byte zero is never part of the complement
                    if (v != 8'h00 && !src_member[v])
                    begin
                        matched = 1'b1;
                        for (int k = 1; k < v; k++)
                            if (!src_member[k])
                                rank++;
                    end
                end
                else if (src_member[v])
                begin
                    matched = 1'b1;
                    rank    = src_pos[v];
                end
                if (matched)
                begin
                    // deleted: nothing out, previous output untouched
                    if (mode_delete)
                        return 1'b0;
                    // empty target leaves the byte as it is
                    if (tgt_len != 0)
                    begin
                        if (rank >= tgt_len)
                            rank = tgt_len - 1;
                        c = tgt_byte[rank[7:0]];
                    end
                end
                if (mode_squeeze && last_out_valid && last_out == c && tgt_member[c])
                begin
                    last_out = c;   // squeezed byte still becomes the previous one
                    return 1'b0;
                end
                last_out_valid = 1'b1;
                last_out       = c;
                mapped         = c;
                return 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, compare each accepted byte in order
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("out_byte %02h with nothing expected", out_byte));
            else
            begin
                wanted_byte = expected_bytes.pop_front();
                if (out_byte !== wanted_byte)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, wanted_byte));
            end
        end
        result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Watchdog: a stuck handshake on either channel ends the run.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One input transaction; random idle cycles ahead of it. Valid stays high
    // on return so back-to-back transactions need no gap.
    task automatic send_item(bxl_pkg::cmd_t op, logic [7:0] v);
        bit [7:0] mapped;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_cmd   <= op;
        item_value <= v;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        if (predict_transliteration(op, v, mapped))
            expected_bytes.push_back(mapped);
        items_sent++;
    endtask

    // Sender holds off until every expected byte is out, then lets the
    // pipeline settle: squeezed or deleted bytes may still be in flight.
    task automatic wait_for_drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // APB write: setup, then access; psel drops cleanly before the task returns.
    task automatic write_register(bxl_pkg::reg_idx_t idx, bit v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            bxl_pkg::REG_COMPLEMENT: mode_complement = v;
            bxl_pkg::REG_DELETE:     mode_delete     = v;
            default:                 mode_squeeze    = v;
        endcase
    endtask

    task automatic set_modes(bit comp, bit del, bit sqz);
        wait_for_drain();
        write_register(bxl_pkg::REG_COMPLEMENT, comp);
        write_register(bxl_pkg::REG_DELETE, del);
        write_register(bxl_pkg::REG_SQUEEZE, sqz);
    endtask

    // Random translates; each repeats the last byte with chance one in three to feed squeeze.
    task automatic translate_burst(int count);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        repeat (count)
        begin
            if ($urandom_range(0, 2) != 0)
                b = 8'($urandom_range(0, 255));
            send_item(bxl_pkg::CMD_XLATE, b);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain mapping after reset: empty sets, repeated source byte, short and
    // empty target, extremes of the byte range, clear.
    task automatic test_directed_mapping();
        send_item(bxl_pkg::CMD_XLATE, 8'h00);
        send_item(bxl_pkg::CMD_XLATE, 8'hFF);
        send_item(bxl_pkg::CMD_SRC,   8'h00);
        send_item(bxl_pkg::CMD_SRC,   8'hFF);
        send_item(bxl_pkg::CMD_SRC,   8'h5A);
        send_item(bxl_pkg::CMD_SRC,   8'h00);   // repeat keeps slot 0
        send_item(bxl_pkg::CMD_XLATE, 8'hFF);   // no target yet: unchanged
        send_item(bxl_pkg::CMD_TGT,   8'hA5);
        send_item(bxl_pkg::CMD_TGT,   8'h3C);
        send_item(bxl_pkg::CMD_XLATE, 8'h00);
        send_item(bxl_pkg::CMD_XLATE, 8'hFF);
        send_item(bxl_pkg::CMD_XLATE, 8'h5A);   // past end of target: last byte
        send_item(bxl_pkg::CMD_XLATE, 8'h81);   // not in source
        send_item(bxl_pkg::CMD_CLEAR, 8'hFF);
        send_item(bxl_pkg::CMD_XLATE, 8'h5A);
    endtask

    // Complement (byte zero passes), then delete and squeeze together.
    task automatic test_directed_modes();
        set_modes(1'b1, 1'b0, 1'b0);
        send_item(bxl_pkg::CMD_SRC,   8'h41);
        send_item(bxl_pkg::CMD_TGT,   8'h7E);
        send_item(bxl_pkg::CMD_XLATE, 8'h00);
        send_item(bxl_pkg::CMD_XLATE, 8'h41);
        send_item(bxl_pkg::CMD_XLATE, 8'h42);   // rank 0x40, beyond target: 0x7E
        set_modes(1'b0, 1'b1, 1'b1);
        send_item(bxl_pkg::CMD_XLATE, 8'h41);   // deleted, previous output stays 0x7E
        send_item(bxl_pkg::CMD_XLATE, 8'h7E);   // squeezed
        send_item(bxl_pkg::CMD_XLATE, 8'h7E);
        send_item(bxl_pkg::CMD_XLATE, 8'h10);
    endtask

    // Both sets filled to capacity and then overrun; the extra appends must
    // neither add members nor overwrite the first target slot.
    task automatic test_full_sets();
        set_modes(1'b0, 1'b0, 1'b1);
        send_item(bxl_pkg::CMD_CLEAR, 8'h00);
        repeat (CAPACITY + 4) send_item(bxl_pkg::CMD_SRC, 8'($urandom_range(0, 255)));
        repeat (CAPACITY + 4) send_item(bxl_pkg::CMD_TGT, 8'($urandom_range(0, 255)));
        translate_burst(80);
        set_modes(1'b1, 1'b0, 1'b1);
        translate_burst(60);
        set_modes(1'b1, 1'b1, 1'b0);
        translate_burst(40);
    endtask

    // Sessions: random modes, usually a clear, small sets, then translates
    // drawn mostly from the sets and repeats, with stray appends as noise.
    task automatic test_random_sessions(int goal, bit pause_once);
        logic [7:0]    src_list [$];
        logic [7:0]    tgt_list [$];
        logic [7:0]    b;
        logic [7:0]    last_b;
        bxl_pkg::cmd_t op;
        int            n_src;
        int            n_tgt;
        int            n_xl;
        int            pick;
        bit            paused;
        paused = 1'b0;
        last_b = 8'h00;
        while (items_sent < goal)
        begin
            set_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) != 0)
            begin
                send_item(bxl_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
                src_list.delete();
                tgt_list.delete();
            end
            n_src = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 16);
            repeat (n_src)
            begin
                if (src_list.size() != 0 && $urandom_range(0, 4) == 0)
                    b = src_list[$urandom_range(0, src_list.size() - 1)];
                else
                    b = 8'($urandom_range(0, 255));
                src_list.push_back(b);
                send_item(bxl_pkg::CMD_SRC, b);
            end
            n_tgt = $urandom_range(0, 12);
            repeat (n_tgt)
            begin
                if (tgt_list.size() != 0 && $urandom_range(0, 4) == 0)
                    b = tgt_list[$urandom_range(0, tgt_list.size() - 1)];
                else
                    b = 8'($urandom_range(0, 255));
                tgt_list.push_back(b);
                send_item(bxl_pkg::CMD_TGT, b);
            end
            n_xl = $urandom_range(10, 40);
            for (int i = 0; i < n_xl; i++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 9)
                begin
                    b  = 8'($urandom_range(0, 255));
                    op = ($urandom_range(0, 1) != 0) ? bxl_pkg::CMD_SRC : bxl_pkg::CMD_TGT;
                    if (op == bxl_pkg::CMD_SRC)
                        src_list.push_back(b);
                    else
                        tgt_list.push_back(b);
                    send_item(op, b);
                end
                else
                begin
                    if (pick <= 3 && src_list.size() != 0)
                        b = src_list[$urandom_range(0, src_list.size() - 1)];
                    else if (pick <= 5)
                        b = last_b;
                    else if (pick <= 7 && tgt_list.size() != 0)
                        b = tgt_list[$urandom_range(0, tgt_list.size() - 1)];
                    else
                        b = 8'($urandom_range(0, 255));
                    send_item(bxl_pkg::CMD_XLATE, b);
                    last_b = b;
                end
                // sender stops mid-stream until the output side has caught up
                if (pause_once && !paused && i == n_xl / 2)
                begin
                    wait_for_drain();
                    paused = 1'b1;
                end
                else if ($urandom_range(0, 63) == 0)
                    wait_for_drain();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles 28%, receiver 45%
        test_directed_mapping();
        test_directed_modes();
        test_random_sessions(260, 1'b1);

        // roles swapped
        send_idle_pct = 45;
        recv_idle_pct = 28;
        test_full_sets();
        test_random_sessions(1150, 1'b0);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sessions(1350, 1'b0);

        item_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE + 4) @(posedge clk);

        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
